### hdl/mutex_group_set_disambiguation_unit_assert.svh
// Assertion macros for the exactly-one group disambiguation unit.
`ifndef MUTEX_GROUP_SET_DISAMBIGUATION_UNIT_ASSERT_SVH
`define MUTEX_GROUP_SET_DISAMBIGUATION_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define MGSD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mgsd assertion failed");
`define MGSD_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("mgsd forbidden condition");
`else
`define MGSD_ASSERT(lbl, clk, rst_n, prop)
`define MGSD_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

### hdl/mgsd_pkg.sv
// Shared codes, control word layout and microprogram of the disambiguation unit.
package mgsd_pkg;

  localparam int MASK_W = 64;

  localparam logic [1:0] FN_ROW   = 2'd0;
  localparam logic [1:0] FN_GROUP = 2'd1;
  localparam logic [1:0] FN_QUERY = 2'd2;
  localparam logic [1:0] FN_NOP   = 2'd3;

  localparam logic [1:0] STS_UNCHANGED = 2'd0;
  localparam logic [1:0] STS_EXTENDED  = 2'd1;
  localparam logic [1:0] STS_UNREACH   = 2'd2;
  localparam logic [1:0] STS_LOADED    = 2'd3;

  localparam logic CFG_FACTS  = 1'b0;
  localparam logic CFG_GROUPS = 1'b1;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE  = 4'd0;
  localparam step_t STEP_DISP  = 4'd1;
  localparam step_t STEP_LOAD  = 4'd2;
  localparam step_t STEP_QINIT = 4'd3;
  localparam step_t STEP_FREAD = 4'd4;
  localparam step_t STEP_FAND  = 4'd5;
  localparam step_t STEP_PASS  = 4'd6;
  localparam step_t STEP_GREAD = 4'd7;
  localparam step_t STEP_GRP   = 4'd8;
  localparam step_t STEP_HIT   = 4'd9;
  localparam step_t STEP_EXT   = 4'd10;
  localparam step_t STEP_NEXT  = 4'd11;
  localparam step_t STEP_PEND  = 4'd12;
  localparam step_t STEP_FIN   = 4'd13;
  localparam step_t STEP_UNR   = 4'd14;
  localparam step_t STEP_OUT   = 4'd15;

  typedef enum logic [3:0] {
    OP_NONE, OP_ACCEPT, OP_LOAD, OP_QINIT, OP_FREAD, OP_FAND, OP_PASS,
    OP_GREAD, OP_GRP, OP_EXT, OP_NEXT, OP_FIN, OP_UNR, OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER, C_ALWAYS, C_NO_REQ, C_QUERY, C_NO_GROUPS, C_MORE_FACTS,
    C_DEAD, C_NO_HIT, C_MORE_GROUPS, C_PASS_CHG, C_OUT_BUSY
  } cond_e;

  // When the condition holds the sequencer jumps to target, else it steps on.
  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } uword_t;

  function automatic uword_t ucode(step_t step);
    uword_t w;
    w = '{op: OP_NONE, cond: C_NEVER, target: STEP_IDLE};
    unique case (step)
      STEP_IDLE:  w = '{op: OP_ACCEPT, cond: C_NO_REQ,       target: STEP_IDLE};
      STEP_DISP:  w = '{op: OP_NONE,   cond: C_QUERY,        target: STEP_QINIT};
      STEP_LOAD:  w = '{op: OP_LOAD,   cond: C_ALWAYS,       target: STEP_OUT};
      STEP_QINIT: w = '{op: OP_QINIT,  cond: C_NO_GROUPS,    target: STEP_FIN};
      STEP_FREAD: w = '{op: OP_FREAD,  cond: C_NEVER,        target: STEP_IDLE};
      STEP_FAND:  w = '{op: OP_FAND,   cond: C_MORE_FACTS,   target: STEP_FREAD};
      STEP_PASS:  w = '{op: OP_PASS,   cond: C_NEVER,        target: STEP_IDLE};
      STEP_GREAD: w = '{op: OP_GREAD,  cond: C_NEVER,        target: STEP_IDLE};
      STEP_GRP:   w = '{op: OP_GRP,    cond: C_DEAD,         target: STEP_UNR};
      STEP_HIT:   w = '{op: OP_NONE,   cond: C_NO_HIT,       target: STEP_NEXT};
      STEP_EXT:   w = '{op: OP_EXT,    cond: C_NEVER,        target: STEP_IDLE};
      STEP_NEXT:  w = '{op: OP_NEXT,   cond: C_MORE_GROUPS,  target: STEP_GREAD};
      STEP_PEND:  w = '{op: OP_NONE,   cond: C_PASS_CHG,     target: STEP_PASS};
      STEP_FIN:   w = '{op: OP_FIN,    cond: C_ALWAYS,       target: STEP_OUT};
      STEP_UNR:   w = '{op: OP_UNR,    cond: C_NEVER,        target: STEP_IDLE};
      STEP_OUT:   w = '{op: OP_EMIT,   cond: C_OUT_BUSY,     target: STEP_OUT};
      default:    w = '{op: OP_NONE,   cond: C_ALWAYS,       target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

### hdl/mgsd_vmem.sv
// Single-port-write, registered-read memory whose unwritten entries read as a reset word.
module mgsd_vmem #(
  parameter int   DEPTH    = 64,
  parameter int   WIDTH    = 64,
  parameter int   AW       = 6,
  parameter logic RST_ONES = 1'b1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  localparam logic [WIDTH-1:0] RST_WORD = {WIDTH{RST_ONES}};

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= vld_q[raddr_i] ? mem[raddr_i] : RST_WORD;
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/mutex_group_set_disambiguation_unit.sv
// A load goes through dispatch, load and output; a query with no groups skips to finish.
// Other queries AND in the rows of the queried facts, then repeat passes over the groups
// while a pass forces a fact, whose row is ANDed in; an unreachable query stops at its dead
// group. One request at a time: the next is accepted only after the result is registered.
// Reset is asynchronous, active low, and leaves all mutex rows all ones and all groups
// empty through per-entry valid bits; no clearing pass is needed.
module mutex_group_set_disambiguation_unit #(
  parameter int MAX_FACTS  = 64,
  parameter int MAX_GROUPS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [6:0]                 cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 func_i,
  input  logic [5:0]                 slot_i,
  input  logic [mgsd_pkg::MASK_W-1:0] mask_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic [mgsd_pkg::MASK_W-1:0] result_set_o
);

  import mgsd_pkg::*;

  `include "mutex_group_set_disambiguation_unit_assert.svh"

  localparam int FW  = $clog2(MAX_FACTS);
  localparam int NFW = $clog2(MAX_FACTS + 1);
  localparam int GW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int NGW = $clog2(MAX_GROUPS + 1);

  logic [6:0]           facts_q, facts_d;
  logic [4:0]           groups_q, groups_d;
  step_t                pc_q, pc_d;
  logic [1:0]           func_q, func_d;
  logic [5:0]           slot_q, slot_d;
  logic [MAX_FACTS-1:0] mask_q, mask_d;
  logic [MAX_FACTS-1:0] work_q, work_d;
  logic [MAX_FACTS-1:0] allow_q, allow_d;
  logic [MAX_FACTS-1:0] pset_q, pset_d;
  logic [FW-1:0]        cnt_q, cnt_d;
  logic [GW-1:0]        g_q, g_d;
  logic                 chg_q, chg_d;
  logic                 pchg_q, pchg_d;
  logic                 hit_q, hit_d;
  logic [1:0]           sts_q, sts_d;
  logic [MAX_FACTS-1:0] res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  logic [1:0]           out_sts_q, out_sts_d;
  logic [MAX_FACTS-1:0] out_set_q, out_set_d;

  uword_t               uw;
  logic                 jump;
  logic [NFW-1:0]       nf;
  logic [FW-1:0]        nf_last;
  logic [NGW-1:0]       ng;
  logic [GW-1:0]        ng_last;
  logic [MAX_FACTS-1:0] fmask;
  logic [MAX_FACTS-1:0] row_rd, gm_rd, cand;
  logic                 gopen, cand_any, cand_one, dead, hit;
  logic [FW-1:0]        ext;
  logic                 row_we, grp_we, row_re, grp_re;
  logic [FW-1:0]        row_raddr;
  logic                 out_no_set;

  assign uw = ucode(pc_q);

  // Clamped fact and group counts.
  always_comb begin
    if (facts_q == 7'd0) begin
      nf = NFW'(1);
    end else if (facts_q > MAX_FACTS) begin
      nf = NFW'(MAX_FACTS);
    end else begin
      nf = NFW'(facts_q);
    end
    if (groups_q > MAX_GROUPS) begin
      ng = NGW'(MAX_GROUPS);
    end else begin
      ng = NGW'(groups_q);
    end
    nf_last = FW'(nf - NFW'(1));
    ng_last = GW'(ng - NGW'(1));
    for (int i = 0; i < MAX_FACTS; i++) begin
      fmask[i] = (NFW'(i) < nf);
    end
  end

  // Group test: open means no member in the set as it stood at the start of the pass.
  always_comb begin
    cand     = gm_rd & fmask & allow_q;
    gopen    = ~|(gm_rd & fmask & pset_q);
    cand_any = |cand;
    cand_one = cand_any && ~|(cand & (cand - MAX_FACTS'(1)));
    dead     = gopen && !cand_any;
    hit      = gopen && cand_one;
    ext      = '0;
    for (int i = 0; i < MAX_FACTS; i++) begin
      if (cand[i]) begin
        ext = ext | FW'(i);
      end
    end
  end

  always_comb begin
    unique case (uw.cond)
      C_NEVER:       jump = 1'b0;
      C_ALWAYS:      jump = 1'b1;
      C_NO_REQ:      jump = !in_valid_i;
      C_QUERY:       jump = (func_q == FN_QUERY);
      C_NO_GROUPS:   jump = (ng == '0);
      C_MORE_FACTS:  jump = (cnt_q != nf_last);
      C_DEAD:        jump = dead;
      C_NO_HIT:      jump = !hit_q;
      C_MORE_GROUPS: jump = (g_q != ng_last);
      C_PASS_CHG:    jump = pchg_q;
      C_OUT_BUSY:    jump = out_valid_q && !out_ready_i;
      default:       jump = 1'b0;
    endcase
    pc_d = jump ? uw.target : step_t'(pc_q + 1'b1);
  end

  assign in_ready_o = (uw.op == OP_ACCEPT);
  assign row_we     = (uw.op == OP_LOAD) && (func_q == FN_ROW) && (slot_q < MAX_FACTS);
  assign grp_we     = (uw.op == OP_LOAD) && (func_q == FN_GROUP) && (slot_q < MAX_GROUPS);
  assign row_re     = (uw.op == OP_FREAD) || ((uw.op == OP_GRP) && hit);
  assign grp_re     = (uw.op == OP_GREAD);
  assign row_raddr  = (uw.op == OP_GRP) ? ext : cnt_q;

  // Datapath driven by the current control word.
  always_comb begin
    facts_d     = facts_q;
    groups_d    = groups_q;
    func_d      = func_q;
    slot_d      = slot_q;
    mask_d      = mask_q;
    work_d      = work_q;
    allow_d     = allow_q;
    pset_d      = pset_q;
    cnt_d       = cnt_q;
    g_d         = g_q;
    chg_d       = chg_q;
    pchg_d      = pchg_q;
    hit_d       = hit_q;
    sts_d       = sts_q;
    res_d       = res_q;
    out_sts_d   = out_sts_q;
    out_set_d   = out_set_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cfg_we_i) begin
      if (cfg_idx_i == CFG_FACTS) begin
        facts_d = cfg_data_i;
      end else begin
        groups_d = cfg_data_i[4:0];
      end
    end

    unique case (uw.op)
      OP_ACCEPT: begin
        if (in_valid_i) begin
          func_d = func_i;
          slot_d = slot_i;
          mask_d = mask_i[MAX_FACTS-1:0];
        end
      end
      OP_LOAD: begin
        sts_d = (func_q == FN_NOP) ? STS_UNCHANGED : STS_LOADED;
        res_d = '0;
      end
      OP_QINIT: begin
        work_d  = mask_q & fmask;
        allow_d = fmask;
        cnt_d   = '0;
        chg_d   = 1'b0;
      end
      OP_FAND: begin
        if (work_q[cnt_q]) begin
          allow_d = allow_q & row_rd;
        end
        cnt_d = cnt_q + 1'b1;
      end
      OP_PASS: begin
        pset_d = work_q;
        pchg_d = 1'b0;
        g_d    = '0;
      end
      OP_GRP: begin
        hit_d = hit;
        if (hit) begin
          work_d = work_q | cand;
          chg_d  = 1'b1;
          pchg_d = 1'b1;
        end
      end
      OP_EXT: begin
        allow_d = allow_q & row_rd;
      end
      OP_NEXT: begin
        g_d = g_q + 1'b1;
      end
      OP_FIN: begin
        sts_d = chg_q ? STS_EXTENDED : STS_UNCHANGED;
        res_d = work_q;
      end
      OP_UNR: begin
        sts_d = STS_UNREACH;
        res_d = '0;
      end
      OP_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_sts_d   = sts_q;
          out_set_d   = res_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      facts_q     <= 7'd64;
      groups_q    <= '0;
      pc_q        <= STEP_IDLE;
      func_q      <= FN_NOP;
      slot_q      <= '0;
      mask_q      <= '0;
      work_q      <= '0;
      allow_q     <= '0;
      pset_q      <= '0;
      cnt_q       <= '0;
      g_q         <= '0;
      chg_q       <= 1'b0;
      pchg_q      <= 1'b0;
      hit_q       <= 1'b0;
      sts_q       <= STS_UNCHANGED;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_sts_q   <= STS_UNCHANGED;
      out_set_q   <= '0;
    end else begin
      facts_q     <= facts_d;
      groups_q    <= groups_d;
      pc_q        <= pc_d;
      func_q      <= func_d;
      slot_q      <= slot_d;
      mask_q      <= mask_d;
      work_q      <= work_d;
      allow_q     <= allow_d;
      pset_q      <= pset_d;
      cnt_q       <= cnt_d;
      g_q         <= g_d;
      chg_q       <= chg_d;
      pchg_q      <= pchg_d;
      hit_q       <= hit_d;
      sts_q       <= sts_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_sts_q   <= out_sts_d;
      out_set_q   <= out_set_d;
    end
  end

  // Rows hold the complement of the loaded mutex partners.
  mgsd_vmem #(
    .DEPTH   (MAX_FACTS),
    .WIDTH   (MAX_FACTS),
    .AW      (FW),
    .RST_ONES(1'b1)
  ) u_rows (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (row_we),
    .waddr_i(slot_q[FW-1:0]),
    .wdata_i(~mask_q),
    .re_i   (row_re),
    .raddr_i(row_raddr),
    .rdata_o(row_rd)
  );

  mgsd_vmem #(
    .DEPTH   (MAX_GROUPS),
    .WIDTH   (MAX_FACTS),
    .AW      (GW),
    .RST_ONES(1'b0)
  ) u_groups (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (grp_we),
    .waddr_i(slot_q[GW-1:0]),
    .wdata_i(mask_q),
    .re_i   (grp_re),
    .raddr_i(g_q),
    .rdata_o(gm_rd)
  );

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_sts_q;
  assign result_set_o = MASK_W'(out_set_q);

  // Loads and unreachable queries carry an empty set.
  assign out_no_set = (status_o == STS_UNREACH) || (status_o == STS_LOADED);

  `MGSD_ASSERT(a_ext_marks_change, clk_i, rst_ni, (pc_q == STEP_EXT) |-> (chg_q && pchg_q))
  `MGSD_NEVER(a_walk_in_range, clk_i, rst_ni, (pc_q == STEP_GRP) && (g_q > ng_last))
  `MGSD_ASSERT(a_empty_result, clk_i, rst_ni, (out_valid_o && out_no_set) |-> (result_set_o == '0))

endmodule
